/* rtl/pfarc_pkg.sv */
package pfarc_pkg;

    localparam int NUM_PAGES_DEF  = 8192;
    localparam int COUNT_BITS_DEF = 16;

    localparam int MODE_W     = 3;
    localparam int PAGE_W     = 13;
    localparam int CFG_W      = 14;
    localparam int STATUS_W   = 2;
    localparam int REFC_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INIT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FREE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INCREF = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DECREF = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOMEM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ERR   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_PAGES = 1'b1;

    localparam logic [CFG_W-1:0] TOTAL_PAGES_RST    = 14'd8192;
    localparam logic [CFG_W-1:0] RESERVED_PAGES_RST = 14'd0;

    typedef struct packed {
        logic              went_free;
        logic [REFC_W-1:0] ref_count;
        logic [PAGE_W-1:0] page_out;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

/* rtl/page_frame_allocator_refcount_core.sv */
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: mode[2:0], page[15:3]
//  m_        out  m_tvalid/m_tready  m_tdata: status[1:0], page_out[14:2],
//                                             ref_count[30:15], went_free[31]
//  cfg_      in   cfg_wr_en          cfg_index, cfg_wdata
//
//  Free, incref, decref and unused modes read the count on accept, then modify/write in ST_EXEC;
//  alloc pops the stack, reads the count, then writes back; an empty stack skips both reads.
//  Init sweeps every page once, then reports from the write-back state.
//  After reset a clearing pass over every page runs with s_tready low.
//  A result waits in the output register; a second result holds in the
//  write-back cycle until m_tready frees the register.
module page_frame_allocator_refcount_core #(
    parameter int NUM_PAGES  = pfarc_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = pfarc_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pfarc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfarc_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // mode[2:0], page[15:3]
    input  logic [pfarc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], page_out[14:2], ref_count[30:15], went_free[31]
    output logic [pfarc_pkg::M_TDATA_W-1:0]  m_tdata
);

    import pfarc_pkg::*;

    localparam int PAGE_AW = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam int TW      = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;
    localparam int ENTRY_W = COUNT_BITS + 1;

    localparam logic [TW-1:0]         NUM_PAGES_T = TW'(NUM_PAGES);
    localparam logic [DEPTH_W-1:0]    STACK_FULL  = DEPTH_W'(NUM_PAGES);
    localparam logic [PAGE_AW-1:0]    LAST_PAGE   = PAGE_AW'(NUM_PAGES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE   = COUNT_BITS'(1);

    typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_EXEC, ST_SWEEP} state_t;

    function automatic logic [REFC_W-1:0] to_refc(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[REFC_W-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [PAGE_AW-1:0]   act_reg, act_next;
    logic                 empty_reg, empty_next;
    logic                 sweep_init_reg, sweep_init_next;
    logic [PAGE_AW-1:0]   sweep_idx_reg, sweep_idx_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    result_t              result_reg, result_next;
    logic [CFG_W-1:0]     total_pages_reg, total_pages_next;
    logic [CFG_W-1:0]     reserved_reg, reserved_next;

    // count memory: {on_free_list, count}
    logic                 st_we, st_re;
    logic [PAGE_AW-1:0]   st_waddr, st_raddr;
    logic [ENTRY_W-1:0]   st_wdata, st_rdata;
    logic                 stk_we, stk_re;
    logic [PAGE_AW-1:0]   stk_waddr, stk_raddr;
    logic [PAGE_AW-1:0]   stk_wdata, stk_rdata;

    logic [MODE_W-1:0]     in_mode;
    logic [PAGE_W-1:0]     in_page;
    logic [TW-1:0]         total_ext, eff_total;
    logic                  out_free, can_push, in_range;
    logic [COUNT_BITS-1:0] cur_cnt, dec_cnt;
    logic                  cur_on;
    logic [DEPTH_W-1:0]    depth_dec;

    assign in_mode   = s_tdata[MODE_W-1:0];
    assign in_page   = s_tdata[MODE_W +: PAGE_W];
    assign total_ext = TW'(total_pages_reg);
    assign eff_total = (total_ext > NUM_PAGES_T) ? NUM_PAGES_T : total_ext;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign can_push  = (depth_reg != STACK_FULL);
    assign in_range  = (TW'(page_reg) < eff_total);
    assign cur_cnt   = st_rdata[COUNT_BITS-1:0];
    assign cur_on    = st_rdata[COUNT_BITS];
    assign dec_cnt   = cur_cnt - COUNT_ONE;
    assign depth_dec = depth_reg - DEPTH_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = result_reg;

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        page_next        = page_reg;
        act_next         = act_reg;
        empty_next       = empty_reg;
        sweep_init_next  = sweep_init_reg;
        sweep_idx_next   = sweep_idx_reg;
        depth_next       = depth_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        result_next      = result_reg;
        total_pages_next = total_pages_reg;
        reserved_next    = reserved_reg;

        st_we     = 1'b0;
        st_waddr  = act_reg;
        st_wdata  = '0;
        st_re     = 1'b0;
        st_raddr  = PAGE_AW'(in_page);
        stk_we    = 1'b0;
        stk_waddr = depth_reg[PAGE_AW-1:0];
        stk_wdata = act_reg;
        stk_re    = 1'b0;
        stk_raddr = depth_dec[PAGE_AW-1:0];

        if (cfg_wr_en) begin
            if (cfg_index == REG_TOTAL_PAGES) begin
                total_pages_next = cfg_wdata;
            end else if (cfg_index == REG_RESERVED_PAGES) begin
                reserved_next = cfg_wdata;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next = in_mode;
                    page_next = in_page;
                    act_next  = PAGE_AW'(in_page);
                    case (in_mode)
                        MODE_INIT: begin
                            sweep_init_next = 1'b1;
                            sweep_idx_next  = '0;
                            depth_next      = '0;
                            state_next      = ST_SWEEP;
                        end
                        MODE_ALLOC: begin
                            empty_next = (depth_reg == '0);
                            if (depth_reg != '0) begin
                                stk_re     = 1'b1;
                                depth_next = depth_dec;
                                state_next = ST_POP;
                            end else begin
                                state_next = ST_EXEC;
                            end
                        end
                        default: begin
                            st_re      = 1'b1;
                            state_next = ST_EXEC;
                        end
                    endcase
                end
            end
            ST_POP: begin
                st_re     = 1'b1;
                st_raddr  = stk_rdata;
                act_next  = stk_rdata;
                page_next = PAGE_W'(stk_rdata);
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    result_next   = '0;
                    result_next.status = STATUS_OK;
                    if (mode_reg == MODE_ALLOC) begin
                        if (empty_reg) begin
                            result_next.status = STATUS_NOMEM;
                        end else begin
                            result_next.page_out  = page_reg;
                            result_next.ref_count = to_refc(cur_cnt);
                            st_we    = 1'b1;
                            st_wdata = {1'b0, cur_cnt};
                        end
                    end else if (mode_reg inside {MODE_FREE, MODE_INCREF, MODE_DECREF}) begin
                        result_next.page_out = page_reg;
                        if (!in_range) begin
                            result_next.status = STATUS_RANGE;
                        end else begin
                            case (mode_reg)
                                MODE_FREE: begin
                                    result_next.ref_count = to_refc(cur_cnt);
                                    if (cur_on) begin
                                        result_next.status = STATUS_ERR;
                                    end else if (cur_cnt == '0 && can_push) begin
                                        result_next.went_free = 1'b1;
                                        st_we      = 1'b1;
                                        st_wdata   = {1'b1, cur_cnt};
                                        stk_we     = 1'b1;
                                        depth_next = depth_reg + DEPTH_W'(1);
                                    end
                                end
                                MODE_INCREF: begin
                                    if (cur_cnt == COUNT_MAX) begin
                                        result_next.status    = STATUS_ERR;
                                        result_next.ref_count = to_refc(cur_cnt);
                                    end else begin
                                        result_next.ref_count = to_refc(cur_cnt + COUNT_ONE);
                                        st_we    = 1'b1;
                                        st_wdata = {cur_on, cur_cnt + COUNT_ONE};
                                    end
                                end
                                default: begin
                                    if (cur_cnt == '0) begin
                                        result_next.status = STATUS_ERR;
                                    end else begin
                                        result_next.ref_count = to_refc(dec_cnt);
                                        st_we    = 1'b1;
                                        st_wdata = {cur_on, dec_cnt};
                                        // at zero, push the page unless listed or stack full
                                        if (dec_cnt == '0 && !cur_on && can_push) begin
                                            result_next.went_free = 1'b1;
                                            st_wdata   = {1'b1, dec_cnt};
                                            stk_we     = 1'b1;
                                            depth_next = depth_reg + DEPTH_W'(1);
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            ST_SWEEP: begin
                st_we    = 1'b1;
                st_waddr = sweep_idx_reg;
                st_wdata = '0;
                if (sweep_init_reg && (TW'(sweep_idx_reg) < eff_total)) begin
                    if (TW'(sweep_idx_reg) < TW'(reserved_reg)) begin
                        st_wdata = {1'b0, COUNT_ONE};
                    end else begin
                        st_wdata   = {1'b1, {COUNT_BITS{1'b0}}};
                        stk_we     = 1'b1;
                        stk_wdata  = sweep_idx_reg;
                        depth_next = depth_reg + DEPTH_W'(1);
                    end
                end
                if (sweep_idx_reg == LAST_PAGE) begin
                    // init reports through the write-back cycle; the reset pass does not
                    state_next = sweep_init_reg ? ST_EXEC : ST_IDLE;
                end else begin
                    sweep_idx_next = sweep_idx_reg + PAGE_AW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_SWEEP;
            sweep_init_reg  <= 1'b0;
            sweep_idx_reg   <= '0;
            depth_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
            total_pages_reg <= TOTAL_PAGES_RST;
            reserved_reg    <= RESERVED_PAGES_RST;
        end else begin
            state_reg       <= state_next;
            sweep_init_reg  <= sweep_init_next;
            sweep_idx_reg   <= sweep_idx_next;
            depth_reg       <= depth_next;
            m_tvalid_reg    <= m_tvalid_next;
            total_pages_reg <= total_pages_next;
            reserved_reg    <= reserved_next;
        end
        mode_reg   <= mode_next;
        page_reg   <= page_next;
        act_reg    <= act_next;
        empty_reg  <= empty_next;
        result_reg <= result_next;
    end

    pfarc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    pfarc_ram #(
        .WIDTH (PAGE_AW),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= STACK_FULL)
        else $error("free stack depth beyond page count");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer accepted while an operation is open");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_EXEC))
        else $error("result raised outside the write-back cycle");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |-> ($past(state_reg == ST_IDLE) && !empty_reg))
        else $error("pop issued on empty stack");

endmodule

/* rtl/pfarc_ram.sv */
module pfarc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* bench/page_frame_allocator_refcount_core_tb.sv */
module page_frame_allocator_refcount_core_tb;
    import pfarc_pkg::*;

    localparam int FRAMES     = NUM_PAGES_DEF;
    localparam int CYCLE_CAP  = 1_500_000;
    localparam int HOLD_LEN   = 80;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [MODE_W-1:0] mode;
    } frame_op_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // mode[2:0], page[15:3]
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // status[1:0], page_out[14:2], ref_count[30:15], went_free[31]
    logic [M_TDATA_W-1:0] m_tdata;

    page_frame_allocator_refcount_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow copy of the allocator state
    logic [REFC_W-1:0] shadow_count   [FRAMES];
    logic [PAGE_W-1:0] shadow_stack   [FRAMES];
    logic              shadow_on_list [FRAMES];
    int                shadow_depth    = 0;
    int                shadow_total    = TOTAL_PAGES_RST;
    int                shadow_reserved = RESERVED_PAGES_RST;

    frame_op_t op_queue[$];
    result_t   due_results[$];
    int        ops_open     = 0;
    int        mismatches   = 0;
    int        tx_idle_pct  = 0;
    int        rx_stall_pct = 0;
    int        cycle_count  = 0;
    int        hold_left    = 0;
    logic      hold_req     = 1'b0;
    logic      hold_ack     = 1'b0;

    initial begin
        for (int i = 0; i < FRAMES; i++) begin
            shadow_count[i]   = '0;
            shadow_stack[i]   = '0;
            shadow_on_list[i] = 1'b0;
        end
    end

    function automatic int active_pages();
        return (shadow_total > FRAMES) ? FRAMES : shadow_total;
    endfunction

    function automatic logic stack_push(input int pg);
        if (shadow_depth >= FRAMES)
            return 1'b0;
        shadow_stack[shadow_depth] = PAGE_W'(pg);
        shadow_depth++;
        shadow_on_list[pg] = 1'b1;
        return 1'b1;
    endfunction

    function automatic result_t frame_op_result(input frame_op_t op);
        result_t           r;
        int                lim;
        int                i;
        logic [REFC_W-1:0] c;
        r = '0;
        lim = active_pages();
        if (op.mode == MODE_INIT) begin
            shadow_depth = 0;
            for (i = 0; i < FRAMES; i++) begin
                shadow_count[i]   = '0;
                shadow_on_list[i] = 1'b0;
            end
            for (i = 0; i < lim; i++) begin
                if (i < shadow_reserved)
                    shadow_count[i] = REFC_W'(1);
                else
                    void'(stack_push(i));
            end
        end else if (op.mode == MODE_ALLOC) begin
            if (shadow_depth == 0) begin
                r.status = STATUS_NOMEM;
            end else begin
                shadow_depth--;
                i = shadow_stack[shadow_depth];
                shadow_on_list[i] = 1'b0;
                r.page_out  = PAGE_W'(i);
                r.ref_count = shadow_count[i];
            end
        end else if (op.mode > MODE_DECREF) begin
            // unused codes: all-zero result
        end else if (op.page >= lim) begin
            r.status   = STATUS_RANGE;
            r.page_out = op.page;
        end else begin
            c = shadow_count[op.page];
            r.page_out  = op.page;
            r.ref_count = c;
            case (op.mode)
                MODE_FREE: begin
                    if (shadow_on_list[op.page])
                        r.status = STATUS_ERR;
                    else if (c == 0)
                        r.went_free = stack_push(op.page);
                end
                MODE_INCREF: begin
                    if (&c) begin
                        r.status = STATUS_ERR;
                    end else begin
                        shadow_count[op.page] = c + 1'b1;
                        r.ref_count = c + 1'b1;
                    end
                end
                default: begin
                    if (c == 0) begin
                        r.status = STATUS_ERR;
                    end else begin
                        c = c - 1'b1;
                        shadow_count[op.page] = c;
                        r.ref_count = c;
                        if (c == 0 && !shadow_on_list[op.page])
                            r.went_free = stack_push(op.page);
                    end
                end
            endcase
        end
        return r;
    endfunction

    // driver: prediction is made on the transfer edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                due_results.push_back(frame_op_result(frame_op_t'(s_tdata)));
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_tdata  <= op_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side backpressure, with a long hold-off whenever hold_req toggles
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (due_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: status %0d page %0d count %0d %s %0d",
                             got.status, got.page_out, got.ref_count, "went_free",
                             got.went_free);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                ops_open--;
                if (got.status !== want.status || got.page_out !== want.page_out ||
                    got.ref_count !== want.ref_count || got.went_free !== want.went_free) begin
                    if (mismatches < 10)
                        $display("mismatch: exp st %0d pg %0d cnt %0d wf %0d, %s",
                                 want.status, want.page_out, want.ref_count,
                                 want.went_free,
                                 $sformatf("got st %0d pg %0d cnt %0d wf %0d",
                                           got.status, got.page_out, got.ref_count,
                                           got.went_free));
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send(input logic [MODE_W-1:0] mode, input int pg);
        frame_op_t op;
        op.mode = mode;
        op.page = PAGE_W'(pg);
        op_queue.push_back(op);
        ops_open++;
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_TOTAL_PAGES)
            shadow_total = val;
        else
            shadow_reserved = val;
    endtask

    task automatic wait_idle();
        do @(posedge aclk); while (ops_open != 0);
    endtask

    // mostly ops on pages that are live: top of the stack and the reserved low end
    task automatic queue_random(input int n);
        int lim;
        int pick;
        int pg;
        logic [MODE_W-1:0] mode;
        lim = active_pages();
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                mode = MODE_ALLOC;
            else if (pick < 48)
                mode = MODE_FREE;
            else if (pick < 68)
                mode = MODE_INCREF;
            else if (pick < 94)
                mode = MODE_DECREF;
            else
                mode = MODE_DECREF + MODE_W'($urandom_range(1, 3));
            pick = $urandom_range(0, 99);
            if (pick < 8)
                pg = $urandom_range(0, FRAMES - 1);
            else if (pick < 14)
                pg = lim + $urandom_range(0, 3);
            else if (lim <= 48)
                pg = $urandom_range(0, lim - 1);
            else if (pick < 57)
                pg = $urandom_range(lim - 24, lim - 1);
            else
                pg = $urandom_range(0, 23);
            send(mode, pg);
        end
    endtask

    task automatic set_idle(input int tx, input int rx);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // straight through, from the reset state
        set_idle(0, 0);
        send(MODE_ALLOC, 0);
        send(MODE_DECREF, 0);
        send(MODE_FREE, FRAMES - 1);
        send(MODE_FREE, FRAMES - 1);
        send(MODE_ALLOC, 0);
        send(MODE_DECREF + 3'd1, 0);
        send(MODE_DECREF + 3'd2, FRAMES - 1);
        send(MODE_DECREF + 3'd3, 1234);
        send(MODE_INCREF, FRAMES - 1);
        send(MODE_FREE, FRAMES - 1);
        wait_idle();
        set_reg(REG_TOTAL_PAGES, 16383);
        set_reg(REG_RESERVED_PAGES, 0);
        send(MODE_INIT, 0);
        send(MODE_ALLOC, 0);
        send(MODE_ALLOC, 0);
        send(MODE_INCREF, 100);
        send(MODE_DECREF, 100);
        send(MODE_FREE, 100);
        send(MODE_INCREF, FRAMES - 1);
        send(MODE_DECREF, FRAMES - 1);
        wait_idle();
        hold_req <= ~hold_req;
        queue_random(130);
        wait_idle();

        // sender idles
        set_idle(78, 0);
        set_reg(REG_TOTAL_PAGES, FRAMES);
        set_reg(REG_RESERVED_PAGES, FRAMES);
        send(MODE_INIT, 0);
        send(MODE_ALLOC, 0);
        send(MODE_DECREF, 0);
        send(MODE_ALLOC, 0);
        send(MODE_FREE, FRAMES - 1);
        send(MODE_DECREF, FRAMES - 1);
        send(MODE_DECREF, FRAMES - 1);
        wait_idle();
        set_reg(REG_TOTAL_PAGES, 64);
        set_reg(REG_RESERVED_PAGES, 8);
        send(MODE_INIT, 0);
        queue_random(130);
        wait_idle();

        // receiver stalls
        set_idle(0, 78);
        set_reg(REG_TOTAL_PAGES, 1);
        set_reg(REG_RESERVED_PAGES, 0);
        send(MODE_INIT, 0);
        send(MODE_ALLOC, 0);
        send(MODE_ALLOC, 0);
        send(MODE_FREE, 1);
        send(MODE_INCREF, FRAMES - 1);
        send(MODE_FREE, 0);
        wait_idle();
        set_reg(REG_TOTAL_PAGES, 200);
        set_reg(REG_RESERVED_PAGES, 190);
        send(MODE_INIT, 0);
        queue_random(130);
        wait_idle();

        // both sides pause now and then
        set_idle(11, 11);
        set_reg(REG_TOTAL_PAGES, 100);
        set_reg(REG_RESERVED_PAGES, 200);
        send(MODE_INIT, 0);
        send(MODE_ALLOC, 0);
        send(MODE_DECREF, 99);
        send(MODE_FREE, 100);
        wait_idle();
        set_reg(REG_TOTAL_PAGES, FRAMES);
        set_reg(REG_RESERVED_PAGES, 0);
        send(MODE_INIT, 0);
        wait_idle();
        // shrink below the stacked pages; the pop still hands out the top page
        set_reg(REG_TOTAL_PAGES, 50);
        send(MODE_ALLOC, 0);
        send(MODE_FREE, FRAMES - 1);
        wait_idle();
        set_reg(REG_TOTAL_PAGES, 33);
        send(MODE_INIT, 0);
        queue_random(130);
        wait_idle();

        repeat (16) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
